[rtl/core/ctg_pkg.sv]
package ctg_pkg;

  localparam int SINE_TABLE_BITS = 8;
  localparam int SINE_SIZE       = 1 << SINE_TABLE_BITS;
  localparam int SINE_ADDR_BITS  = SINE_TABLE_BITS + 1;
  localparam int PHASE_BITS      = 32;
  localparam int PHASE_DIGIT     = 8;
  localparam int PHASE_DIGITS    = PHASE_BITS / PHASE_DIGIT;
  localparam int PHASE_CNT_BITS  = $clog2(PHASE_DIGITS);
  localparam int PHASE_TOP_BITS  = SINE_TABLE_BITS + 2;
  localparam int COUNT_BITS      = 16;
  localparam int LEVEL_BITS      = 16;
  localparam int SAMPLE_BITS     = 16;

  localparam int MUL_A_BITS      = 32;
  localparam int MUL_M_BITS      = 16;
  localparam int MUL_DIGIT       = 4;
  localparam int MUL_STEPS       = MUL_M_BITS / MUL_DIGIT;
  localparam int MUL_CNT_BITS    = $clog2(MUL_STEPS);
  localparam int MUL_P_BITS      = MUL_A_BITS + MUL_M_BITS;
  localparam int MUL_PP_BITS     = MUL_A_BITS + MUL_DIGIT;

  localparam int CFG_INDEX_BITS  = 3;
  localparam int CFG_DATA_BITS   = 32;

  localparam logic [CFG_INDEX_BITS-1:0] REG_START_INC  = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SWEEP_STEP = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_COUNT      = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_ENV_STEP   = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_VOLUME     = 3'd4;

  typedef logic [SINE_SIZE:0][SAMPLE_BITS-1:0] lut_t;

  typedef struct packed {
    logic load;
    logic run;
  } phase_ctl_t;

  typedef struct packed {
    logic start;
  } mul_ctl_t;

  // quarter-wave sine, amplitude 32767, Taylor series to x^13 in Q30
  function automatic lut_t build_sine_lut();
    lut_t        t;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] r;
    for (int j = 0; j <= SINE_SIZE; j++) begin
      x    = (64'd1686629713 * 64'(j)) >> SINE_TABLE_BITS;
      x2   = (x * x) >> 30;
      term = x;
      sum  = x;
      term = ((term * x2) >> 30) / 64'd6;
      sum  = sum - term;
      term = ((term * x2) >> 30) / 64'd20;
      sum  = sum + term;
      term = ((term * x2) >> 30) / 64'd42;
      sum  = sum - term;
      term = ((term * x2) >> 30) / 64'd72;
      sum  = sum + term;
      term = ((term * x2) >> 30) / 64'd110;
      sum  = sum - term;
      term = ((term * x2) >> 30) / 64'd156;
      sum  = sum + term;
      if (sum[63]) begin
        sum = 64'd0;
      end
      r    = (sum * 64'd32767 + (64'd1 << 29)) >> 30;
      t[j] = r[SAMPLE_BITS-1:0];
    end
    return t;
  endfunction

  localparam lut_t SINE_LUT = build_sine_lut();

endpackage

[rtl/core/ctg_phase.sv]
module ctg_phase
  import ctg_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  phase_ctl_t                ctl,
  input  logic [PHASE_BITS-2:0]     start_increment,
  input  logic [PHASE_BITS-1:0]     sweep_step,
  output logic [PHASE_TOP_BITS-1:0] phase_top
);

  logic [PHASE_BITS-1:0]     acc;
  logic [PHASE_BITS-1:0]     step;
  logic [PHASE_CNT_BITS-1:0] cnt;
  logic                      busy;
  logic                      c_acc;
  logic                      c_step;
  logic [PHASE_DIGIT:0]      sum_acc;
  logic [PHASE_DIGIT:0]      sum_step;
  logic [PHASE_DIGIT-1:0]    sweep_digit;

  // digits rotate right through both words, least significant first
  assign sweep_digit = sweep_step[{cnt, 3'b000} +: PHASE_DIGIT];
  assign sum_acc  = {1'b0, acc[PHASE_DIGIT-1:0]} + {1'b0, step[PHASE_DIGIT-1:0]}
                  + {{PHASE_DIGIT{1'b0}}, c_acc};
  assign sum_step = {1'b0, step[PHASE_DIGIT-1:0]} + {1'b0, sweep_digit}
                  + {{PHASE_DIGIT{1'b0}}, c_step};
  assign phase_top = acc[PHASE_BITS-1 -: PHASE_TOP_BITS];

  always_ff @(posedge clk) begin
    if (rst) begin
      acc    <= '0;
      step   <= '0;
      cnt    <= '0;
      busy   <= 1'b0;
      c_acc  <= 1'b0;
      c_step <= 1'b0;
    end else if (ctl.load) begin
      acc  <= '0;
      step <= {1'b0, start_increment};
    end else if (ctl.run) begin
      busy   <= 1'b1;
      cnt    <= '0;
      c_acc  <= 1'b0;
      c_step <= 1'b0;
    end else if (busy) begin
      acc    <= {sum_acc[PHASE_DIGIT-1:0], acc[PHASE_BITS-1:PHASE_DIGIT]};
      step   <= {sum_step[PHASE_DIGIT-1:0], step[PHASE_BITS-1:PHASE_DIGIT]};
      c_acc  <= sum_acc[PHASE_DIGIT];
      c_step <= sum_step[PHASE_DIGIT];
      cnt    <= cnt + 1'b1;
      if (cnt == PHASE_CNT_BITS'(PHASE_DIGITS - 1)) begin
        busy <= 1'b0;
      end
    end
  end

endmodule

[rtl/core/ctg_mult.sv]
module ctg_mult
  import ctg_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  mul_ctl_t              ctl,
  input  logic [MUL_A_BITS-1:0] a,
  input  logic [MUL_M_BITS-1:0] m,
  output logic [MUL_P_BITS-1:0] prod,
  output logic                  done
);

  logic [MUL_A_BITS-1:0]   a_r;
  logic [MUL_M_BITS-1:0]   m_r;
  logic [MUL_P_BITS-1:0]   acc;
  logic [MUL_CNT_BITS-1:0] cnt;
  logic                    busy;
  logic [MUL_PP_BITS-1:0]  pp;

  // most significant digit first: acc = acc * 16 + a * digit
  assign pp   = {{MUL_DIGIT{1'b0}}, a_r}
              * {{MUL_A_BITS{1'b0}}, m_r[MUL_M_BITS-1 -: MUL_DIGIT]};
  assign prod = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == MUL_CNT_BITS'(MUL_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      a_r <= a;
      m_r <= m;
      acc <= '0;
    end else if (busy) begin
      acc <= {acc[MUL_P_BITS-MUL_DIGIT-1:0], {MUL_DIGIT{1'b0}}}
           + {{(MUL_P_BITS-MUL_PP_BITS){1'b0}}, pp};
      m_r <= {m_r[MUL_M_BITS-MUL_DIGIT-1:0], {MUL_DIGIT{1'b0}}};
    end
  end

endmodule

[rtl/core/chirp_tone_with_decay.sv]
// Linear chirp tone generator with a falling envelope. Each accepted input word is one
// audio tick and gives exactly one result word: a 16-bit signed sample, a last-sample
// flag and a playing flag. A tick with start_tone set restarts the tone at sample zero.
// An idle tick goes straight from acceptance to the output state with its zero word; a
// tone tick first reads the sine table and then makes the two four-digit passes through
// the shared 32x4-bit serial multiplier (sine times envelope, then times volume),
// while the phase accumulator and its sweep are updated one byte per cycle alongside.
// One word is in work at a time; the result register lets the next tick be accepted
// while a result waits.
// Configuration writes are taken at any time and are meant for when the block is idle.
module chirp_tone_with_decay
  import ctg_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      start_tone,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [SAMPLE_BITS-1:0]    audio_sample,
  output logic                      is_last,
  output logic                      is_playing,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_LOOK = 3'd1;
  localparam logic [2:0] S_MUL1 = 3'd2;
  localparam logic [2:0] S_MUL2 = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0]                state;
  logic [PHASE_BITS-2:0]     start_increment;
  logic [PHASE_BITS-1:0]     sweep_step;
  logic [COUNT_BITS-1:0]     sample_count;
  logic [LEVEL_BITS-1:0]     envelope_step;
  logic [LEVEL_BITS-1:0]     volume_gain;
  logic [LEVEL_BITS-1:0]     env;
  logic [COUNT_BITS-1:0]     idx;
  logic                      playing;
  logic                      neg;
  logic [SAMPLE_BITS-1:0]    res_sample;
  logic                      res_last;
  logic                      res_play;

  logic                      accept;
  logic                      emit;
  logic                      last_c;
  phase_ctl_t                pctl;
  mul_ctl_t                  mctl;
  logic [PHASE_TOP_BITS-1:0] phase_top;
  logic [SINE_ADDR_BITS-1:0] lut_addr;
  logic [SAMPLE_BITS-1:0]    lut_val;
  logic [MUL_A_BITS-1:0]     ma;
  logic [MUL_M_BITS-1:0]     mm;
  logic [MUL_P_BITS-1:0]     mprod;
  logic                      mdone;
  logic [SAMPLE_BITS-1:0]    mag;

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = in_valid && in_ready;
  assign emit      = (state == S_OUT) && (!out_valid || out_ready);

  assign last_c = ({1'b0, idx} + {{COUNT_BITS{1'b0}}, 1'b1}) >= {1'b0, sample_count};

  // quadrants 1 and 3 read the table backwards
  assign lut_addr = phase_top[SINE_TABLE_BITS]
                  ? SINE_ADDR_BITS'(SINE_SIZE) - {1'b0, phase_top[SINE_TABLE_BITS-1:0]}
                  : {1'b0, phase_top[SINE_TABLE_BITS-1:0]};
  assign lut_val  = SINE_LUT[lut_addr];

  assign pctl.load  = accept && start_tone;
  assign pctl.run   = (state == S_LOOK);
  assign mctl.start = (state == S_LOOK) || ((state == S_MUL1) && mdone);
  assign ma = (state == S_LOOK) ? {{(MUL_A_BITS-SAMPLE_BITS){1'b0}}, lut_val}
                                : mprod[MUL_A_BITS-1:0];
  assign mm = (state == S_LOOK) ? env : volume_gain;
  assign mag = mprod[MUL_P_BITS-1 -: SAMPLE_BITS];

  ctg_phase u_phase (
    .clk             (clk),
    .rst             (rst),
    .ctl             (pctl),
    .start_increment (start_increment),
    .sweep_step      (sweep_step),
    .phase_top       (phase_top)
  );

  ctg_mult u_mult (
    .clk  (clk),
    .rst  (rst),
    .ctl  (mctl),
    .a    (ma),
    .m    (mm),
    .prod (mprod),
    .done (mdone)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      start_increment <= '0;
      sweep_step      <= '0;
      sample_count    <= COUNT_BITS'(1);
      envelope_step   <= '1;
      volume_gain     <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_START_INC:  start_increment <= cfg_data[PHASE_BITS-2:0];
        REG_SWEEP_STEP: sweep_step      <= cfg_data[PHASE_BITS-1:0];
        REG_COUNT:      sample_count    <= cfg_data[COUNT_BITS-1:0];
        REG_ENV_STEP:   envelope_step   <= cfg_data[LEVEL_BITS-1:0];
        REG_VOLUME:     volume_gain     <= cfg_data[LEVEL_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      env       <= '0;
      idx       <= '0;
      playing   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && !emit) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (start_tone) begin
              env     <= '1;
              idx     <= '0;
              playing <= 1'b1;
            end
            state <= (start_tone || playing) ? S_LOOK : S_OUT;
          end
        end
        S_LOOK: begin
          env     <= (env > envelope_step) ? env - envelope_step : '0;
          idx     <= idx + 1'b1;
          if (last_c) begin
            playing <= 1'b0;
          end
          state <= S_MUL1;
        end
        S_MUL1: begin
          if (mdone) begin
            state <= S_MUL2;
          end
        end
        S_MUL2: begin
          if (mdone) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (emit) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_sample <= '0;
      res_last   <= 1'b0;
      res_play   <= 1'b0;
    end
    if (state == S_LOOK) begin
      neg      <= phase_top[SINE_TABLE_BITS+1];
      res_last <= last_c;
      res_play <= 1'b1;
    end
    if ((state == S_MUL2) && mdone) begin
      res_sample <= neg ? (~mag + 1'b1) : mag;
    end
    if ((state == S_OUT) && (!out_valid || out_ready)) begin
      audio_sample <= res_sample;
      is_last      <= res_last;
      is_playing   <= res_play;
    end
  end

endmodule
